>>> hdl/rdc_pkg.sv
// rdc_pkg: shared types, constants and the digit-to-ascii function
// for the radix digit converter; no dependencies
`default_nettype none

package rdc_pkg;

    localparam int VALUE_W        = 31;  // width of the value field
    localparam int RADIX_W        = 5;   // width of the radix field
    localparam int CHAR_W         = 7;   // width of an ascii character
    localparam int DIGIT_W        = 4;   // one base-16 digit at most
    localparam int VALUE_BITS_DEF = 31;  // default significant value bits
    localparam int STEP_BITS      = 8;   // quotient bits produced per cycle

    localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] MAX_RADIX = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } t_in_word;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic              bad_radix;
    } t_out_word;

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10)) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else begin
            c = ASCII_A + CHAR_W'(d - DIGIT_W'(10));
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rdc_div_step.sv
// rdc_div_step: restoring long-division slice, STEP_BITS quotient bits
// against a 5-bit divisor per use; depends on rdc_pkg
`default_nettype none

module rdc_div_step
    import rdc_pkg::*;
(
    input  wire logic [STEP_BITS-1:0] i_chunk,
    input  wire logic [DIGIT_W-1:0]   i_rem,
    input  wire logic [RADIX_W-1:0]   i_radix,
    output logic      [STEP_BITS-1:0] o_quo,
    output logic      [DIGIT_W-1:0]   o_rem
);

    always_comb begin
        logic [RADIX_W-1:0] t;
        logic [DIGIT_W-1:0] r;
        r     = i_rem;
        o_quo = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            t = {r, i_chunk[i]};
            // remainder stays below the radix, so the difference fits 4 bits
            if (t >= i_radix) begin
                o_quo[i] = 1'b1;
                r        = DIGIT_W'(t - i_radix);
            end else begin
                r        = t[DIGIT_W-1:0];
            end
        end
        o_rem = r;
    end

endmodule

`default_nettype wire

>>> hdl/rdc_stack.sv
// rdc_stack: digit stack memory, one write and one registered read port
// depends on rdc_pkg
`default_nettype none

module rdc_stack
    import rdc_pkg::*;
#(
    parameter int DEPTH = VALUE_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [DIGIT_W-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [DIGIT_W-1:0] o_rdata
);

    logic [DIGIT_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/radix_digit_converter.sv
// radix_digit_converter: top level, sequencer around the shared division
// slice and the digit stack; depends on rdc_pkg, rdc_div_step, rdc_stack
`default_nettype none

// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+-----------------------------
// in      | input     | i_in_valid / o_in_ready    | i_in_word  (value, radix)
// out     | output    | o_out_valid / i_out_ready  | o_out_word (digit_char, last,
//         |           |                            |             bad_radix)
//
// steps: one division by the radix runs the running quotient through the shared
//   8-bit division slice chunk by chunk; each digit then leaves through the
//   stack read state and then the show state, where it waits out any output stall
// a conversion holds the input off until its last digit word has been taken;
//   a bad radix gives its single error word in the cycle after it is accepted
// reset clears the sequencer and the digit count; the stack needs no clearing
// the output word waits as long as i_out_ready stays low

module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    // division is done on a word padded up to whole 8-bit chunks
    localparam int PASSES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int QW     = PASSES * STEP_BITS;
    localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int AW     = $clog2(VALUE_BITS);
    localparam int CW     = $clog2(VALUE_BITS + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;  // dividing the running quotient
    localparam logic [1:0] S_READ = 2'd2;  // fetching the next digit
    localparam logic [1:0] S_SHOW = 2'd3;  // word on the output

    logic [1:0]         r_state, n_state;
    logic [QW-1:0]      r_work,  n_work;   // running quotient, shifted in place
    logic [DIGIT_W-1:0] r_rem,   n_rem;    // partial remainder of this division
    logic [RADIX_W-1:0] r_radix, n_radix;
    logic [PW-1:0]      r_pass,  n_pass;   // chunk counter inside one division
    logic [CW-1:0]      r_cnt,   n_cnt;    // digits pushed so far
    logic [AW-1:0]      r_idx,   n_idx;    // stack slot being emitted
    logic               r_err,   n_err;

    logic [STEP_BITS-1:0] quo_chunk;
    logic [DIGIT_W-1:0]   rem_next;
    logic [QW-1:0]        work_next;
    logic [QW-1:0]        value_mask;
    logic                 radix_bad;
    logic                 stack_we;
    logic                 stack_re;
    logic [DIGIT_W-1:0]   stack_rdata;

    // shared division slice: top chunk of the running quotient each cycle
    rdc_div_step u_div (
        .i_chunk (r_work[QW-1 -: STEP_BITS]),
        .i_rem   (r_rem),
        .i_radix (r_radix),
        .o_quo   (quo_chunk),
        .o_rem   (rem_next)
    );

    rdc_stack #(
        .DEPTH (VALUE_BITS),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (rem_next),
        .i_re    (stack_re),
        .i_raddr (r_idx),
        .o_rdata (stack_rdata)
    );

    always_comb begin
        for (int i = 0; i < QW; i++) begin
            value_mask[i] = (i < VALUE_BITS);
        end
    end

    // quotient after this cycle's chunk
    generate
        if (QW > STEP_BITS) begin : g_shift
            assign work_next = {r_work[QW-STEP_BITS-1:0], quo_chunk};
        end else begin : g_single
            assign work_next = quo_chunk;
        end
    endgenerate

    assign radix_bad = (i_in_word.radix < MIN_RADIX) || (i_in_word.radix > MAX_RADIX);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_SHOW);
    assign stack_re    = (r_state == S_READ);
    // a digit is pushed when the last chunk of a division goes through
    assign stack_we    = (r_state == S_DIV) && (r_pass == PW'(PASSES - 1));

    always_comb begin
        if (r_err) begin
            o_out_word.digit_char = CHAR_NONE;
            o_out_word.last       = 1'b1;
            o_out_word.bad_radix  = 1'b1;
        end else begin
            o_out_word.digit_char = ascii_of(stack_rdata);
            o_out_word.last       = (r_idx == '0);
            o_out_word.bad_radix  = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_work  = r_work;
        n_rem   = r_rem;
        n_radix = r_radix;
        n_pass  = r_pass;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_err   = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (radix_bad) begin
                        // error word only, stack and count untouched
                        n_err   = 1'b1;
                        n_state = S_SHOW;
                    end else begin
                        n_err   = 1'b0;
                        n_work  = QW'(i_in_word.value) & value_mask;
                        n_radix = i_in_word.radix;
                        n_rem   = '0;
                        n_pass  = '0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_work = work_next;
                if (r_pass == PW'(PASSES - 1)) begin
                    // division done: remainder goes to the stack this cycle
                    n_cnt  = r_cnt + CW'(1);
                    n_rem  = '0;
                    n_pass = '0;
                    if (work_next == '0) begin
                        n_idx   = r_cnt[AW-1:0];
                        n_state = S_READ;
                    end
                end else begin
                    n_rem  = rem_next;
                    n_pass = r_pass + PW'(1);
                end
            end
            S_READ: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (i_out_ready) begin
                    if (r_err || (r_idx == '0)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pass  <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_idx   <= n_idx;
    end

endmodule

`default_nettype wire

>>> tb/sv/rdc_checker.sv
// rdc_checker: watches both channels of the radix digit converter, predicts the
// digit words for every accepted input word and compares them; depends on rdc_pkg
`timescale 1ns / 1ps

module rdc_checker
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_word  i_in_word,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_word i_out_word,
    output int             o_fail_count,
    output int             o_pending
);

    t_out_word expected_digits[$];
    int        mismatches;

    assign o_fail_count = mismatches;

    task automatic report_error(input string msg);
        $display("error at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DIGIT_W'(10)) begin
            ch = ASCII_ZERO + CHAR_W'(d);
        end else begin
            ch = ASCII_A + CHAR_W'(d) - CHAR_W'(10);
        end
        return ch;
    endfunction

    // divide down, keep remainders least significant first, queue them msd first
    function automatic void predict_digits(input t_in_word w);
        logic [DIGIT_W-1:0] rems [VALUE_W];
        logic [VALUE_W-1:0] quot;
        logic [VALUE_W-1:0] base;
        t_out_word          word;
        int                 count;
        if (w.radix < MIN_RADIX || w.radix > MAX_RADIX) begin
            word.digit_char = CHAR_NONE;
            word.last       = 1'b1;
            word.bad_radix  = 1'b1;
            expected_digits.push_back(word);
        end else begin
            base  = VALUE_W'(w.radix);
            quot  = w.value & VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);
            count = 0;
            do begin
                rems[count] = DIGIT_W'(quot % base);
                quot        = quot / base;
                count++;
            end while (quot != '0 && count < VALUE_BITS);
            for (int k = count - 1; k >= 0; k--) begin
                word.digit_char = digit_to_char(rems[k]);
                word.last       = (k == 0);
                word.bad_radix  = 1'b0;
                expected_digits.push_back(word);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            expected_digits.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_digits(i_in_word);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_digits.size() == 0) begin
                    report_error($sformatf("unexpected word char=%h last=%b bad=%b",
                        i_out_word.digit_char, i_out_word.last, i_out_word.bad_radix));
                end else begin
                    want = expected_digits.pop_front();
                    if (i_out_word.digit_char !== want.digit_char ||
                        i_out_word.last !== want.last ||
                        i_out_word.bad_radix !== want.bad_radix) begin
                        report_error($sformatf(
                            "char=%h/%h last=%b/%b bad=%b/%b (got/want)",
                            i_out_word.digit_char, want.digit_char,
                            i_out_word.last, want.last,
                            i_out_word.bad_radix, want.bad_radix));
                    end
                end
            end
        end
        o_pending <= expected_digits.size();
    end

endmodule

>>> tb/sv/tb_radix_digit_converter.sv
// tb_radix_digit_converter: stimulus and verdict for the radix digit converter;
// depends on rdc_pkg, radix_digit_converter and rdc_checker
`timescale 1ns / 1ps

module tb_radix_digit_converter
    import rdc_pkg::*;
();

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 210;
    localparam int QUIET_WORDS  = 40;   // tail of the run with no idling
    localparam int DRAIN_CYCLES = 200;  // watch for stray words after the last one
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;
    int        fail_count;
    int        outstanding;

    // set for the final stretch: both sides stop idling
    logic quiet = 1'b0;
    // remaining cycles of the current receiver stall
    int   stall_left = 0;

    radix_digit_converter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    rdc_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (outstanding)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard stop in case the converter hangs or words go missing
    initial begin
        #2_000_000;
        $display("FAIL radix_digit_converter");
        $finish;
    end

    // receiver: drops ready for random stalls, ready high otherwise
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // present one word, maybe after a short gap, and hold it until accepted;
    // valid is left high so a following word can go out back to back
    task automatic send_word(input logic [VALUE_W-1:0] value, input logic [RADIX_W-1:0] radix);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_word.value <= value;
        in_word.radix <= radix;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // drop valid and hold off until every predicted digit word has come out;
    // first let the checker see the last accepted word
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial begin
        int                 sel;
        int                 pick;
        logic [RADIX_W-1:0] radix;
        logic [VALUE_W-1:0] value;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bases out of range: one error word each
        send_word(VALUE_W'(5), RADIX_W'(0));
        send_word(VALUE_MAX, RADIX_W'(1));
        send_word(VALUE_W'(0), RADIX_W'(17));
        send_word(VALUE_MAX, RADIX_W'(31));
        // zero gives a single '0' at both ends of the base range
        send_word(VALUE_W'(0), MIN_RADIX);
        send_word(VALUE_W'(0), MAX_RADIX);
        // largest value: 31 binary digits, and the decimal and hex forms
        send_word(VALUE_MAX, MIN_RADIX);
        send_word(VALUE_MAX, RADIX_W'(10));
        send_word(VALUE_MAX, MAX_RADIX);
        // every base with the largest single digit, no leading zero expected
        for (int r = 2; r <= 16; r++) begin
            send_word(VALUE_W'(r - 1), RADIX_W'(r));
        end
        // value equal to the base rolls over to two digits
        send_word(VALUE_W'(16), MAX_RADIX);

        // let the directed words drain fully before the random part
        wait_drained();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS - QUIET_WORDS) begin
                quiet = 1'b1;
            end
            if (i == RANDOM_WORDS / 2) begin
                wait_drained();
            end

            // mostly legal bases, some from both sides of the legal range
            sel = $urandom_range(0, 19);
            if (sel < 3) begin
                pick  = $urandom_range(0, 16);
                radix = (pick < 2) ? RADIX_W'(pick) : RADIX_W'(pick + 15);
            end else begin
                radix = RADIX_W'($urandom_range(2, 16));
            end

            // full-width values dominate, short ones keep digit counts varied
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                value = VALUE_W'($urandom);
            end else if (sel < 8) begin
                value = VALUE_W'($urandom_range(0, 300));
            end else if (sel == 8) begin
                value = VALUE_MAX;
            end else begin
                value = VALUE_W'($urandom_range(0, 16));
            end

            send_word(value, radix);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("PASS radix_digit_converter");
        end else begin
            $display("FAIL radix_digit_converter");
        end
        $finish;
    end

endmodule
